// ===== design/huf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Huffman byte encoder package
// Shared widths, action codes and the lookup record passed from the table
// to the bit packer.
// ============================================================================

package huf_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int PAD_W  = 3;
    localparam int PEND_W = 3;
    localparam int ACC_W  = CODE_W + BYTE_W;
    localparam int CNT_W  = 6;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              eom;
    } lookup_t;

endpackage

// ===== design/huf_table.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Huffman code table
// Code and length memories with registered reads, per-entry valid
// bits for the length store, and the lookup stage register.
// ============================================================================

module huf_table
    import huf_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        symbol,
    input  logic [CODE_W-1:0] code_word,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              end_of_message,
    input  logic              lk_take,
    output logic              lk_valid,
    output lookup_t           lk
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SAT_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0]      code_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]       len_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] len_valid_reg;

    logic [CODE_W-1:0] rd_code_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_lv_reg;
    logic              rd_eom_reg;
    logic              rd_valid_reg;

    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic             wr_en;
    logic             rd_en;
    logic [LEN_W-1:0] len_sat;

    assign in_ready = !rd_valid_reg || lk_take;
    assign accept   = in_valid && in_ready;
    assign in_range = {1'b0, symbol} < 9'(TABLE_DEPTH);
    assign idx      = symbol[IDX_W-1:0];
    assign wr_en    = accept && (action == ACT_LOAD) && in_range;
    assign rd_en    = accept && (action == ACT_ENCODE);
    assign len_sat  = (code_length > LEN_W'(SAT_LEN)) ? LEN_W'(SAT_LEN) : code_length;

    // Memory writes and registered reads. A load and an encode never share
    // an edge, and a read after a write sees the new contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[idx] <= code_word;
            len_mem[idx]  <= len_sat;
        end
        if (rd_en && in_range)
        begin
            rd_code_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
        end
        if (rd_en)
        begin
            rd_eom_reg <= end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
            rd_lv_reg     <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                len_valid_reg[idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_lv_reg    <= in_range && len_valid_reg[idx];
                rd_valid_reg <= 1'b1;
            end
            else if (lk_take)
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    assign lk_valid = rd_valid_reg;
    assign lk.code  = rd_code_reg;
    assign lk.len   = rd_lv_reg ? rd_len_reg : '0;
    assign lk.eom   = rd_eom_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !lk_take |=> rd_valid_reg)
        else $error("lookup stage dropped an unconsumed entry");

    a_load_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> len_valid_reg[$past(idx)])
        else $error("loaded entry not marked valid");

endmodule

// ===== design/huf_packer.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Huffman bit packer
// Merges pending bits with a looked-up code in a left-aligned accumulator and
// emits one byte per cycle into the output register while it is not stalled.
// ============================================================================

module huf_packer
    import huf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              lk_valid,
    input  lookup_t           lk,
    output logic              lk_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic [PAD_W-1:0]  pad_count,
    output logic              last_byte
);

    logic [ACC_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              eom_reg, eom_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic              last_reg;

    logic              need_emit;
    logic              out_free;
    logic              emit;
    logic              emit_last;
    logic [PAD_W-1:0]  emit_pad;
    logic [ACC_W-1:0]  post_buf;
    logic [CNT_W-1:0]  post_cnt;
    logic              post_need;
    logic              free;
    logic [BYTE_W-1:0] pend_bits;
    logic [PEND_W-1:0] pend_cnt;
    logic [CODE_W-1:0] aligned;
    logic [ACC_W-1:0]  new_buf;
    logic [CNT_W-1:0]  new_cnt;

    assign need_emit = (cnt_reg >= CNT_W'(BYTE_W)) || (eom_reg && cnt_reg != '0);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = need_emit && out_free;
    assign emit_last = eom_reg && (cnt_reg <= CNT_W'(BYTE_W));
    assign emit_pad  = (cnt_reg < CNT_W'(BYTE_W)) ? PAD_W'(CNT_W'(BYTE_W) - cnt_reg) : '0;

    assign post_buf  = emit ? (buf_reg << BYTE_W) : buf_reg;
    assign post_cnt  = !emit ? cnt_reg
                     : (cnt_reg >= CNT_W'(BYTE_W)) ? cnt_reg - CNT_W'(BYTE_W) : '0;
    assign post_need = (post_cnt >= CNT_W'(BYTE_W)) || (eom_reg && post_cnt != '0);
    assign free      = !post_need;
    assign lk_take   = free && lk_valid;

    // Bits left over once the current item is done; a message end drops them.
    assign pend_bits = eom_reg ? '0 : post_buf[ACC_W-1 -: BYTE_W];
    assign pend_cnt  = eom_reg ? '0 : post_cnt[PEND_W-1:0];

    // Left-align the code, then place it right behind the pending bits.
    assign aligned = lk.code << (LEN_W'(CODE_W) - lk.len);
    assign new_buf = {pend_bits, {CODE_W{1'b0}}} | ({aligned, {BYTE_W{1'b0}}} >> pend_cnt);
    assign new_cnt = CNT_W'(pend_cnt) + CNT_W'(lk.len);

    always_comb
    begin
        if (lk_take)
        begin
            buf_next = new_buf;
            cnt_next = new_cnt;
            eom_next = lk.eom;
        end
        else if (free)
        begin
            buf_next = {pend_bits, {CODE_W{1'b0}}};
            cnt_next = CNT_W'(pend_cnt);
            eom_next = 1'b0;
        end
        else
        begin
            buf_next = post_buf;
            cnt_next = post_cnt;
            eom_next = eom_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            eom_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
            eom_reg <= eom_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= buf_reg[ACC_W-1 -: BYTE_W];
            pad_reg      <= emit_pad;
            last_reg     <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign pad_count = pad_reg;
    assign last_byte = last_reg;

    a_pad_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> pad_reg == '0)
        else $error("pad bits reported on a byte that is not last");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_last |-> free)
        else $error("item still busy after its last byte");

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ACC_W - 1))
        else $error("accumulator bit count out of range");

endmodule

// ===== design/huffman_byte_encoder_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Huffman byte encoder core
// Static-table Huffman encoder: loads code words, packs codes into bytes.
// ============================================================================
//
// Usage: the input channel carries one transaction per item. With action at
// load, the symbol's code word and length (saturated to MAX_CODE_LEN and 32)
// are written to the code table; no output follows. With action at encode,
// the symbol's code is looked up and appended MSB first to the bit
// accumulator; every completed byte leaves on the output channel with its
// earliest bit in bit 7. With end_of_message set, leftover bits are padded
// with zeros and that byte is flagged last with its pad count.
// A byte passes from its encode transaction through the lookup stage, the
// packer's accumulator and the output register. The packer emits one byte per
// cycle while the output is free and takes the next item with the current
// one's final byte; the table takes one transaction per cycle unless stalled.
// Reset clears the accumulator and marks every table length as zero at once.
// When the receiver stalls, the output register holds its byte, the packer
// and lookup stage fill, and input ready drops until space frees up.
// ============================================================================

module huffman_byte_encoder_core
    import huf_pkg::*;
#(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        symbol,
    input  logic [CODE_W-1:0] code_word,
    input  logic [LEN_W-1:0]  code_length,
    input  logic              end_of_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic [PAD_W-1:0]  pad_count,
    output logic              last_byte
);

    lookup_t lk;
    logic    lk_valid;
    logic    lk_take;

    // Table memories plus the registered lookup stage.
    huf_table #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .symbol         (symbol),
        .code_word      (code_word),
        .code_length    (code_length),
        .end_of_message (end_of_message),
        .lk_take        (lk_take),
        .lk_valid       (lk_valid),
        .lk             (lk)
    );

    // Accumulator and byte emitter; it takes the next lookup in the same
    // cycle as it emits the current item's final byte.
    huf_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .lk_valid  (lk_valid),
        .lk        (lk),
        .lk_take   (lk_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .pad_count (pad_count),
        .last_byte (last_byte)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Huffman byte encoder testbench
// Loads code words into the encoder's table, encodes messages with random
// handshake gaps on both channels and checks every packed byte, pad count
// and last flag against a cycle-free model of the bit packer.
// ============================================================================

module testbench;

    import huf_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int TAIL_CYCLES  = 20;

    // One input transaction, or a marker that makes the sender wait until
    // every expected byte has come back.
    typedef struct {
        bit                drain;
        logic              act;
        logic [7:0]        sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              eom;
        int                gap;
    } huf_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [PAD_W-1:0]  pad;
        logic              last;
    } packed_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              action = ACT_LOAD;
    logic [7:0]        symbol = '0;
    logic [CODE_W-1:0] code_word = '0;
    logic [LEN_W-1:0]  code_length = '0;
    logic              end_of_message = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic [PAD_W-1:0]  pad_count;
    logic              last_byte;

    huffman_byte_encoder_core #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .symbol         (symbol),
        .code_word      (code_word),
        .code_length    (code_length),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .pad_count      (pad_count),
        .last_byte      (last_byte)
    );

    // Pending stimulus and the bytes the packer model says must come out.
    huf_item_t    stim_q[$];
    packed_byte_t expected_bytes[$];

    // Model state: the code table and the partial byte being assembled.
    logic [CODE_W-1:0] tbl_code [TABLE_DEPTH];
    logic [LEN_W-1:0]  tbl_len  [TABLE_DEPTH];
    logic [7:0]        acc_bits = '0;
    int                acc_cnt = 0;

    // Handshake bookkeeping and error count for the sampling and driving blocks.
    int n_issued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int rx_seen    = 0;
    int in_gap     = 0;
    int rx_stall   = 0;
    int rx_streak  = 0;
    int errors     = 0;

    // Stimulus-side statistics and generator state.
    bit tx_calm = 1'b0;
    bit gen_loaded [TABLE_DEPTH];
    int loaded_syms[$];
    int n_loads    = 0;
    int n_encodes  = 0;
    int n_messages = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the encoder
    // ------------------------------------------------------------------------

    task automatic store_code(input logic [7:0] sym, input logic [CODE_W-1:0] word,
                              input logic [LEN_W-1:0] len);
        int eff;
        eff = len;
        if (eff > MAX_CODE_LEN)
            eff = MAX_CODE_LEN;
        if (eff > CODE_W)
            eff = CODE_W;
        if (sym < TABLE_DEPTH) begin
            tbl_code[sym] = word;
            tbl_len[sym]  = eff[LEN_W-1:0];
        end
    endtask

    // Appends a symbol's code to the partial byte. A finished byte is held
    // back by one step so that an end of message landing exactly on a byte
    // boundary can still mark it as last.
    task automatic pack_symbol(input logic [7:0] sym, input logic eom);
        logic [CODE_W-1:0] code;
        int                clen;
        int                i;
        packed_byte_t      held;
        bit                have_held;
        have_held = 1'b0;
        held = '{default: '0};
        code = tbl_code[sym];
        clen = tbl_len[sym];
        if (clen > CODE_W)
            clen = CODE_W;
        for (i = clen; i > 0; i--) begin
            acc_bits = {acc_bits[6:0], code[i-1]};
            acc_cnt++;
            if (acc_cnt == BYTE_W) begin
                if (have_held)
                    expected_bytes.insert(expected_bytes.size(), held);
                held = '{data: acc_bits, pad: '0, last: 1'b0};
                have_held = 1'b1;
                acc_bits = '0;
                acc_cnt = 0;
            end
        end
        if (eom) begin
            if (acc_cnt > 0) begin
                if (have_held)
                    expected_bytes.insert(expected_bytes.size(), held);
                held.data = acc_bits << (BYTE_W - acc_cnt);
                held.pad  = PAD_W'(BYTE_W - acc_cnt);
                held.last = 1'b1;
                have_held = 1'b1;
            end else if (have_held) begin
                held.last = 1'b1;
            end
            acc_bits = '0;
            acc_cnt = 0;
        end
        if (have_held)
            expected_bytes.insert(expected_bytes.size(), held);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation helpers
    // ------------------------------------------------------------------------

    task automatic add_item(input logic act, input logic [7:0] sym,
                            input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len,
                            input logic eom);
        huf_item_t it;
        it.drain = 1'b0;
        it.act   = act;
        it.sym   = sym;
        it.word  = word;
        it.len   = len;
        it.eom   = eom;
        it.gap   = tx_calm ? 0 : $urandom_range(0, 3);
        stim_q.insert(stim_q.size(), it);
        if (act == ACT_LOAD) begin
            n_loads++;
            if (!gen_loaded[sym]) begin
                gen_loaded[sym] = 1'b1;
                loaded_syms.insert(loaded_syms.size(), int'(sym));
            end
        end else begin
            n_encodes++;
            if (eom)
                n_messages++;
        end
    endtask

    task automatic add_drain();
        huf_item_t it;
        it = '{default: '0};
        it.drain = 1'b1;
        stim_q.insert(stim_q.size(), it);
    endtask

    // Code lengths lean short so that messages pack many symbols, with a
    // share of long codes, empty codes and lengths that must saturate.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 12)
            return LEN_W'($urandom_range(33, 63));
        else if (r < 27)
            return LEN_W'($urandom_range(17, 32));
        else
            return LEN_W'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------------
    // Sampling at the rising edge: check output transactions first, then
    // fold any accepted input transaction into the model.
    // ------------------------------------------------------------------------

    always @(posedge clk) begin
        packed_byte_t exp_b;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                n_results <= n_results + 1;
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected byte out_byte=%02h pad_count=%0d last_byte=%0b",
                             $time, out_byte, pad_count, last_byte);
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (out_byte !== exp_b.data) begin
                        errors++;
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, exp_b.data, out_byte);
                    end
                    if (pad_count !== exp_b.pad) begin
                        errors++;
                        $display("%0t: pad_count expected %0d actual %0d",
                                 $time, exp_b.pad, pad_count);
                    end
                    if (last_byte !== exp_b.last) begin
                        errors++;
                        $display("%0t: last_byte expected %0b actual %0b",
                                 $time, exp_b.last, last_byte);
                    end
                end
            end
            if (in_valid && in_ready) begin
                n_accepted <= n_accepted + 1;
                if (action == ACT_LOAD)
                    store_code(symbol, code_word, code_length);
                else
                    pack_symbol(symbol, end_of_message);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input driver, falling edge. An item stays on the port until accepted;
    // then the gap drawn for it runs down before the next one goes out.
    // ------------------------------------------------------------------------

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (n_issued != n_accepted) begin
            // Transaction still waiting for ready: hold everything.
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (stim_q.size() > 0 && !stim_q[0].drain) begin
            action         <= stim_q[0].act;
            symbol         <= stim_q[0].sym;
            code_word      <= stim_q[0].word;
            code_length    <= stim_q[0].len;
            end_of_message <= stim_q[0].eom;
            in_gap         <= stim_q[0].gap;
            in_valid       <= 1'b1;
            n_issued       <= n_issued + 1;
            void'(stim_q.pop_front());
        end else begin
            in_valid <= 1'b0;
            if (stim_q.size() > 0 && expected_bytes.size() == 0)
                void'(stim_q.pop_front());
        end
    end

    // ------------------------------------------------------------------------
    // Output ready, falling edge. A stall is drawn after each output transaction
    // outside a streak; now and then a streak of results goes through unstalled.
    // ------------------------------------------------------------------------

    always @(negedge clk) begin
        int s;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (n_results != rx_seen) begin
            rx_seen <= n_results;
            s = 0;
            if (rx_streak > 0)
                rx_streak <= rx_streak - 1;
            else if ($urandom_range(0, 15) == 0)
                rx_streak <= 20;
            else
                s = $urandom_range(0, 3);
            out_ready <= (s == 0);
            rx_stall <= (s > 0) ? s - 1 : 0;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------

    initial begin
        int k;
        int r;
        logic [7:0] s;

        // Directed: a code of length zero, the widest codes, saturating
        // lengths, an overwrite, and each way a message can end.
        add_item(ACT_LOAD, 8'h00, 32'h0000_0000, 6'd0, 1'b1);
        add_item(ACT_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b0);
        add_item(ACT_LOAD, 8'h41, 32'h0000_0005, 6'd3, 1'b0);
        add_item(ACT_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd63, 1'b0);
        add_item(ACT_LOAD, 8'h01, 32'hFFFF_FFFE, 6'd1, 1'b1);
        add_item(ACT_LOAD, 8'h7E, 32'h0000_005A, 6'd8, 1'b0);
        add_item(ACT_LOAD, 8'h22, 32'h5555_5555, 6'd33, 1'b0);
        add_item(ACT_LOAD, 8'h33, 32'h0000_0001, 6'd1, 1'b0);
        add_item(ACT_LOAD, 8'h33, 32'h0000_0002, 6'd2, 1'b0);
        // Empty code alone ends a message that has produced nothing.
        add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b1);
        add_item(ACT_ENCODE, 8'h41, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h41, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h7E, '0, '0, 1'b1);
        // Exactly one byte: it carries the last flag with no padding.
        add_item(ACT_ENCODE, 8'h7E, '0, '0, 1'b1);
        add_item(ACT_ENCODE, 8'hFF, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h80, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h01, '0, '0, 1'b1);
        // Three pending bits plus a 32-bit code: the largest burst of bytes.
        add_item(ACT_ENCODE, 8'h41, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'hFF, '0, '0, 1'b1);
        add_item(ACT_ENCODE, 8'h22, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h33, '0, '0, 1'b0);
        add_item(ACT_ENCODE, 8'h00, '0, '0, 1'b1);
        add_drain();

        // Random: mostly messages built from loaded symbols, with table
        // updates sprinkled in between.
        for (k = 0; k < 250; k++) begin
            if (k % 30 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if (k == 125)
                add_drain();
            r = $urandom_range(0, 99);
            if (r < 15) begin
                s = 8'($urandom_range(0, TABLE_DEPTH - 1));
                add_item(ACT_LOAD, s, CODE_W'($urandom), pick_length(),
                         1'($urandom_range(0, 1)));
            end else begin
                s = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
                add_item(ACT_ENCODE, s, CODE_W'($urandom), LEN_W'($urandom_range(0, 63)),
                         ($urandom_range(0, 7) == 0));
            end
        end
        // Close the final message so no bits stay stranded in the packer.
        add_item(ACT_ENCODE, 8'h41, '0, '0, 1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() > 0 || n_issued != n_accepted || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("testbench: %0d table loads and %0d encodes in %0d messages",
                 n_loads, n_encodes, n_messages);
        $display("testbench: %0d output bytes checked, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("testbench: timeout");
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/huf_pkg.sv
design/huf_table.sv
design/huf_packer.sv
design/huffman_byte_encoder_core.sv
verif/testbench.sv
